/* rtl/rtt_smoother_rto_estimator_assert.svh */
// assertion macros for the round-trip estimator
`ifndef RTT_SMOOTHER_RTO_ESTIMATOR_ASSERT_SVH
`define RTT_SMOOTHER_RTO_ESTIMATOR_ASSERT_SVH

// condition and consequence in the same cycle
`define RSE_ASSERT_SAME(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// consequence in the cycle after the condition
`define RSE_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rse_pkg.sv */
// shared types and constants for the round-trip estimator
package rse_pkg;

  localparam int TimeW = 64;
  localparam int RtoW  = 36;

  localparam logic [RtoW-1:0] RtoFloorReset   = 36'd200000000;
  localparam logic [RtoW-1:0] RtoCeilingReset = 36'd30000000000;
  localparam logic [RtoW-1:0] RtoInitialReset = 36'd1000000000;

  typedef enum logic [1:0] {
    RSE_IDX_FLOOR   = 2'd0,
    RSE_IDX_CEILING = 2'd1,
    RSE_IDX_INITIAL = 2'd2
  } rse_idx_t;

  typedef struct packed {
    logic             have;
    logic [TimeW-1:0] srtt;
    logic [TimeW-1:0] rttvar;
  } rse_est_t;

  typedef struct packed {
    logic [RtoW-1:0] floor_ns;
    logic [RtoW-1:0] ceiling_ns;
    logic [RtoW-1:0] initial_ns;
  } rse_cfg_t;

endpackage

/* rtl/rtt_smoother_rto_estimator.sv */
// round-trip smoother and retransmit timeout estimator, top level
// a word passes through stage one, stage two and the output register; one word per cycle unless out_stall holds it
// stage one registers the timestamps, the state update runs into stage two,
// the clamp runs into the output register; each stage moves on when the next is free
// synchronous reset clears valids and estimator state and loads the default
// floor, ceiling and initial timeout
module rtt_smoother_rto_estimator import rse_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [RtoW-1:0]  cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [TimeW-1:0] submit_time,
  input  logic [TimeW-1:0] now_time,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             sample_taken,
  output logic [RtoW-1:0]  rto_value,
  output logic [TimeW-1:0] smoothed_rtt,
  output logic [TimeW-1:0] rtt_variation
);

  rse_cfg_t         cfg;
  rse_est_t         est;
  rse_est_t         est_next;
  logic             s1_valid;
  logic [TimeW-1:0] s1_submit;
  logic [TimeW-1:0] s1_now;
  logic             s2_valid;
  logic             s2_taken;
  logic             taken_next;
  logic             s1_adv;
  logic             s2_adv;
  logic [RtoW-1:0]  rto_next;

  assign s2_adv   = !out_valid || !out_stall;
  assign s1_adv   = !s2_valid || s2_adv;
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.floor_ns   <= RtoFloorReset;
      cfg.ceiling_ns <= RtoCeilingReset;
      cfg.initial_ns <= RtoInitialReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RSE_IDX_FLOOR:   cfg.floor_ns   <= cfg_data;
        RSE_IDX_CEILING: cfg.ceiling_ns <= cfg_data;
        RSE_IDX_INITIAL: cfg.initial_ns <= cfg_data;
        default: ;
      endcase
    end
  end

  rse_update u_update (
    .est         (est),
    .submit_time (s1_submit),
    .now_time    (s1_now),
    .est_next    (est_next),
    .taken       (taken_next)
  );

  rse_clamp u_clamp (
    .est (est),
    .cfg (cfg),
    .rto (rto_next)
  );

  // stage one: timestamps
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_submit <= submit_time;
      s1_now    <= now_time;
    end
  end

  // stage two: estimator state doubles as the stage payload
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      est      <= '0;
    end else if (s1_adv) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        est <= est_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      s2_taken <= taken_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_valid) begin
      sample_taken  <= s2_taken;
      rto_value     <= rto_next;
      smoothed_rtt  <= est.srtt;
      rtt_variation <= est.rttvar;
    end
  end

  `include "rtt_smoother_rto_estimator_assert.svh"

  `RSE_ASSERT_NEXT(a_state_holds, !(s1_valid && s1_adv), $stable(est),
    "estimator state changed without a word leaving stage one")
  `RSE_ASSERT_SAME(a_taken_has_sample, s2_valid && s2_taken, est.have,
    "sample taken but estimator has no sample")
  `RSE_ASSERT_SAME(a_srtt_nonzero, est.have, est.srtt != '0,
    "smoothed rtt is zero after a sample")
  `RSE_ASSERT_SAME(a_rto_ceiling, est.have, rto_next <= cfg.ceiling_ns,
    "timeout above ceiling")

endmodule

/* rtl/rse_update.sv */
// estimator state update for one timestamp pair
module rse_update import rse_pkg::*; (
  input  rse_est_t         est,
  input  logic [TimeW-1:0] submit_time,
  input  logic [TimeW-1:0] now_time,
  output rse_est_t         est_next,
  output logic             taken
);

  logic [TimeW-1:0] sample;
  logic [TimeW-1:0] diff;
  logic [TimeW+1:0] var_sum;
  logic [TimeW+2:0] srtt_sum;

  assign taken  = (submit_time != '0) && (now_time > submit_time);
  assign sample = now_time - submit_time;
  assign diff   = (est.srtt > sample) ? (est.srtt - sample) : (sample - est.srtt);

  // 3*var + |srtt - sample|, exact
  assign var_sum = {2'b00, est.rttvar} + {1'b0, est.rttvar, 1'b0} + {2'b00, diff};
  // 7*srtt + sample, exact
  assign srtt_sum = {est.srtt, 3'b000} - {3'b000, est.srtt} + {3'b000, sample};

  always_comb begin
    est_next = est;
    if (taken) begin
      est_next.have = 1'b1;
      if (!est.have) begin
        est_next.srtt   = sample;
        est_next.rttvar = {1'b0, sample[TimeW-1:1]};
      end else begin
        est_next.rttvar = var_sum[TimeW+1:2];
        est_next.srtt   = srtt_sum[TimeW+2:3];
      end
    end
  end

endmodule

/* rtl/rse_clamp.sv */
// timeout from the estimator state, clamped to floor and ceiling; the initial timeout until a sample is held
module rse_clamp import rse_pkg::*; (
  input  rse_est_t        est,
  input  rse_cfg_t        cfg,
  output logic [RtoW-1:0] rto
);

  logic [TimeW:0]   sum;
  logic             over;
  logic [TimeW-1:0] clamped;

  assign sum  = {1'b0, est.srtt} + {1'b0, est.rttvar[TimeW-3:0], 2'b00};
  // carry out of the sum, or rttvar bits lost to the shift, counts as above every ceiling
  assign over = (est.rttvar[TimeW-1:TimeW-2] != 2'b00) || sum[TimeW];

  always_comb begin
    clamped = sum[TimeW-1:0];
    if (!over && clamped < {{(TimeW-RtoW){1'b0}}, cfg.floor_ns}) begin
      clamped = {{(TimeW-RtoW){1'b0}}, cfg.floor_ns};
    end
    if (over || clamped > {{(TimeW-RtoW){1'b0}}, cfg.ceiling_ns}) begin
      clamped = {{(TimeW-RtoW){1'b0}}, cfg.ceiling_ns};
    end
    rto = est.have ? clamped[RtoW-1:0] : cfg.initial_ns;
  end

endmodule
